// ===== sv/slu_pkg.sv =====
// ---------------------------------------------------------------------------
// slu_pkg
// Shared types, result codes and helper functions for the literal unescaper.
// ---------------------------------------------------------------------------
package slu_pkg;

    // default depth of the queue between front and back
    localparam int QueueDepthDefault = 4;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LITERAL   = 3'd1;
    localparam logic [2:0] ERR_HEX_ASCII = 3'd2;
    localparam logic [2:0] ERR_HEX_UNI   = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;
    localparam logic [2:0] ERR_TRUNC     = 3'd5;
    localparam logic [2:0] ERR_LEAD      = 3'd6;

    // one decoded input byte: up to four results of the same kind
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      err;
        logic [1:0]      cnt_m1;   // number of results minus one
        logic [3:0][7:0] bytes;    // result bytes, entry 0 goes first
    } job_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esc_t;

    typedef struct packed {
        logic [1:0]      cnt_m1;
        logic [3:0][7:0] bytes;
    } enc_t;

    // hex digit value; bit 4 set marks a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            v = 5'h10;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = {1'b0, 4'(c - 8'h30)};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v = {1'b0, 4'(c - 8'h57)};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                v = {1'b0, 4'(c - 8'h37)};
            end
            return v;
        end
    endfunction

    // simple backslash escapes
    function automatic esc_t esc_lookup(input logic [7:0] c);
        esc_t r;
        begin
            r.hit = 1'b1;
            case (c)
                8'h27:   r.value = 8'h27;   // single quote
                8'h22:   r.value = 8'h22;   // double quote
                8'h5C:   r.value = 8'h5C;   // backslash
                8'h30:   r.value = 8'h00;   // '0'
                8'h61:   r.value = 8'h07;   // 'a'
                8'h62:   r.value = 8'h08;   // 'b'
                8'h66:   r.value = 8'h0C;   // 'f'
                8'h6E:   r.value = 8'h0A;   // 'n'
                8'h72:   r.value = 8'h0D;   // 'r'
                8'h74:   r.value = 8'h09;   // 't'
                8'h76:   r.value = 8'h0B;   // 'v'
                default:
                begin
                    r.hit   = 1'b0;
                    r.value = 8'h00;
                end
            endcase
            return r;
        end
    endfunction

    // UTF-8 encoding of a code point up to 21 bits
    function automatic enc_t utf8_encode(input logic [20:0] u);
        enc_t r;
        begin
            r.bytes = '0;
            if (u <= 21'h7F)
            begin
                r.cnt_m1   = 2'd0;
                r.bytes[0] = {1'b0, u[6:0]};
            end
            else if (u <= 21'h7FF)
            begin
                r.cnt_m1   = 2'd1;
                r.bytes[0] = {3'b110, u[10:6]};
                r.bytes[1] = {2'b10, u[5:0]};
            end
            else if (u <= 21'hFFFF)
            begin
                r.cnt_m1   = 2'd2;
                r.bytes[0] = {4'b1110, u[15:12]};
                r.bytes[1] = {2'b10, u[11:6]};
                r.bytes[2] = {2'b10, u[5:0]};
            end
            else
            begin
                r.cnt_m1   = 2'd3;
                r.bytes[0] = {5'b11110, u[20:18]};
                r.bytes[1] = {2'b10, u[17:12]};
                r.bytes[2] = {2'b10, u[11:6]};
                r.bytes[3] = {2'b10, u[5:0]};
            end
            return r;
        end
    endfunction

endpackage

// ===== sv/string_literal_unescape.sv =====
// ---------------------------------------------------------------------------
// string_literal_unescape
// Streaming unescaper for the body of a double-quoted text literal.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_byte) takes one raw body byte per
// transfer, starting after the opening quote. Output channel
// (out_valid/out_ready) gives results: out_byte, kind (data, end, error),
// error_code and last, which marks the final result of one input byte.
// Bytes inside an escape give no result; a \u escape gives 1 to 4 bytes.
// A job is written into the queue at its input transfer and moved into the
// output register once that register is free. Throughput: one input byte
// per cycle while each byte yields at most one result and the receiver
// keeps up; the output register drains one result per cycle while
// out_ready is high, so a four-byte \u burst holds the serializer while the
// job queue absorbs the input. in_ready falls only when the queue is full.
// After an end or error result the next byte starts a new literal.
// Reset returns the parser to the literal body and empties queue and
// output register. A stalled receiver holds the current result steady.
// ---------------------------------------------------------------------------
module string_literal_unescape #(
    parameter int QUEUE_DEPTH = slu_pkg::QueueDepthDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic [2:0] error_code,
    output logic       last
);

    logic          push_valid;
    logic          push_ready;
    slu_pkg::job_t push_data;
    logic          pop_valid;
    logic          pop_ready;
    slu_pkg::job_t pop_data;

    // parser
    slu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_data)
    );

    // job queue
    slu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // result serializer
    slu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job        (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last)
    );

endmodule

// ===== sv/slu_front.sv =====
// ---------------------------------------------------------------------------
// slu_front
// Parses one input byte per transfer and builds the job of its results.
// ---------------------------------------------------------------------------
module slu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              job_valid,
    input  logic              job_ready,
    output slu_pkg::job_t     job
);

    localparam logic [2:0] MODE_BODY = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_HEXA = 3'd2;
    localparam logic [2:0] MODE_HEXU = 3'd3;
    localparam logic [2:0] MODE_CONT = 3'd4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;

    logic [2:0]  mode_reg,   mode_next;
    logic [2:0]  digits_reg, digits_next;
    logic [20:0] accum_reg,  accum_next;
    logic [1:0]  cont_reg,   cont_next;

    logic                accept;
    logic                emit;
    logic                fail;
    logic [2:0]          fail_code;
    logic [4:0]          hex;
    logic [20:0]         accum_shift;
    slu_pkg::esc_t       esc;
    slu_pkg::enc_t       enc;
    slu_pkg::job_t       job_d;

    // the byte is taken whenever the queue has room
    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = accept && (emit || fail);

    assign hex         = slu_pkg::hex_value(in_byte);
    assign esc         = slu_pkg::esc_lookup(in_byte);
    assign accum_shift = {accum_reg[16:0], hex[3:0]};
    assign enc         = slu_pkg::utf8_encode(accum_shift);

    // per-byte decode
    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        accum_next  = accum_reg;
        cont_next   = cont_reg;
        emit        = 1'b0;
        fail        = 1'b0;
        fail_code   = slu_pkg::ERR_NONE;
        job_d       = '0;
        job_d.kind  = slu_pkg::KIND_DATA;

        case (mode_reg)
            MODE_ESC:
            begin
                if (in_byte == CH_X)
                begin
                    mode_next   = MODE_HEXA;
                    digits_next = 3'd2;
                    accum_next  = '0;
                end
                else if (in_byte == CH_U)
                begin
                    mode_next   = MODE_HEXU;
                    digits_next = 3'd6;
                    accum_next  = '0;
                end
                else if (esc.hit)
                begin
                    mode_next      = MODE_BODY;
                    emit           = 1'b1;
                    job_d.bytes[0] = esc.value;
                end
                else
                begin
                    fail      = 1'b1;
                    fail_code = slu_pkg::ERR_LITERAL;
                end
            end

            MODE_HEXA:
            begin
                if (digits_reg >= 3'd2)
                begin
                    if (in_byte >= CH_ZERO && in_byte <= CH_SEVEN)
                    begin
                        accum_next  = {17'd0, hex[3:0]};
                        digits_next = 3'd1;
                    end
                    else
                    begin
                        fail      = 1'b1;
                        fail_code = slu_pkg::ERR_HEX_ASCII;
                    end
                end
                else if (hex[4])
                begin
                    fail      = 1'b1;
                    fail_code = slu_pkg::ERR_HEX_ASCII;
                end
                else
                begin
                    emit           = 1'b1;
                    job_d.bytes[0] = {accum_reg[3:0], hex[3:0]};
                    mode_next      = MODE_BODY;
                    digits_next    = '0;
                    accum_next     = '0;
                    cont_next      = '0;
                end
            end

            MODE_HEXU:
            begin
                // digit checks by position
                if (digits_reg >= 3'd6)
                begin
                    fail = !(in_byte == CH_ZERO || in_byte == CH_ONE);
                end
                else if (digits_reg == 3'd5)
                begin
                    fail = hex[4] || (accum_reg == 21'd1 && hex[3:0] != 4'd0);
                end
                else
                begin
                    fail = hex[4];
                end
                fail_code = slu_pkg::ERR_HEX_UNI;

                if (!fail)
                begin
                    accum_next  = accum_shift;
                    digits_next = digits_reg - 3'd1;
                    if (digits_next == 3'd0)
                    begin
                        if (accum_shift >= 21'hD800 && accum_shift <= 21'hDFFF)
                        begin
                            fail      = 1'b1;
                            fail_code = slu_pkg::ERR_SURROGATE;
                        end
                        else if (accum_shift > 21'h10FFFF)
                        begin
                            fail      = 1'b1;
                            fail_code = slu_pkg::ERR_HEX_UNI;
                        end
                        else
                        begin
                            emit         = 1'b1;
                            job_d.cnt_m1 = enc.cnt_m1;
                            job_d.bytes  = enc.bytes;
                            mode_next    = MODE_BODY;
                            digits_next  = '0;
                            accum_next   = '0;
                            cont_next    = '0;
                        end
                    end
                end
            end

            MODE_CONT:
            begin
                if (in_byte[7:6] != 2'b10)
                begin
                    fail      = 1'b1;
                    fail_code = slu_pkg::ERR_TRUNC;
                end
                else
                begin
                    emit           = 1'b1;
                    job_d.bytes[0] = in_byte;
                    cont_next      = cont_reg - 2'd1;
                    if (cont_next == 2'd0)
                    begin
                        mode_next = MODE_BODY;
                    end
                end
            end

            default:
            begin
                // literal body
                if (in_byte == CH_QUOTE)
                begin
                    emit        = 1'b1;
                    job_d.kind  = slu_pkg::KIND_END;
                    mode_next   = MODE_BODY;
                    digits_next = '0;
                    accum_next  = '0;
                    cont_next   = '0;
                end
                else if (!in_byte[7])
                begin
                    if (in_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (in_byte == CH_LF || in_byte == CH_NUL)
                    begin
                        fail      = 1'b1;
                        fail_code = slu_pkg::ERR_LITERAL;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        job_d.bytes[0] = in_byte;
                    end
                end
                else if (in_byte >= 8'hC0 && in_byte <= 8'hF7)
                begin
                    emit           = 1'b1;
                    job_d.bytes[0] = in_byte;
                    mode_next      = MODE_CONT;
                    if (in_byte >= 8'hF0)
                    begin
                        cont_next = 2'd3;
                    end
                    else if (in_byte >= 8'hE0)
                    begin
                        cont_next = 2'd2;
                    end
                    else
                    begin
                        cont_next = 2'd1;
                    end
                end
                else
                begin
                    fail      = 1'b1;
                    fail_code = slu_pkg::ERR_LEAD;
                end
            end
        endcase

        // any error returns to the literal body
        if (fail)
        begin
            emit        = 1'b0;
            job_d       = '0;
            job_d.kind  = slu_pkg::KIND_ERR;
            job_d.err   = fail_code;
            mode_next   = MODE_BODY;
            digits_next = '0;
            accum_next  = '0;
            cont_next   = '0;
        end
    end

    assign job = job_d;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BODY;
            digits_reg <= '0;
            accum_reg  <= '0;
            cont_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            accum_reg  <= accum_next;
            cont_reg   <= cont_next;
        end
    end

endmodule

// ===== sv/slu_queue.sv =====
// ---------------------------------------------------------------------------
// slu_queue
// Small job queue between the parser and the result serializer.
// ---------------------------------------------------------------------------
module slu_queue #(
    parameter int DEPTH = slu_pkg::QueueDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  slu_pkg::job_t     push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output slu_pkg::job_t     pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    slu_pkg::job_t   entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntFull);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/slu_back.sv =====
// ---------------------------------------------------------------------------
// slu_back
// Serializes each job into one to four results through an output register.
// ---------------------------------------------------------------------------
module slu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  slu_pkg::job_t     job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic [1:0]        kind,
    output logic [2:0]        error_code,
    output logic              last
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg,   idx_next;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic [2:0] err_reg;
    logic       last_reg;

    logic       load;
    logic       job_done;

    // output register is free when empty or being drained
    assign load     = job_valid && (!valid_reg || out_ready);
    assign job_done = (idx_reg == job.cnt_m1);
    assign job_ready = load && job_done;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = job_done ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= job.bytes[idx_reg];
            kind_reg <= job.kind;
            err_reg  <= job.err;
            last_reg <= job_done;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign kind       = kind_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming literal unescaper.
// A table of directed bytes comes first: the byte extremes, the largest
// \u code point and each error path. Random token streams follow: plain
// text, simple escapes, \x and \u escapes, UTF-8 passthrough, closing
// quotes and broken sequences, under four sender/receiver idle patterns.
// Typed directed rows carry their expected result; a behavioral predictor
// gives the rest. Each output transfer is checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int BytesPerPhase = 112;
    localparam int DrainCycles = 8;

    // result kinds and error codes
    localparam logic [1:0] KIND_DATA     = slu_pkg::KIND_DATA;
    localparam logic [1:0] KIND_END      = slu_pkg::KIND_END;
    localparam logic [1:0] KIND_ERR      = slu_pkg::KIND_ERR;
    localparam logic [2:0] ERR_NONE      = slu_pkg::ERR_NONE;
    localparam logic [2:0] ERR_LITERAL   = slu_pkg::ERR_LITERAL;
    localparam logic [2:0] ERR_HEX_ASCII = slu_pkg::ERR_HEX_ASCII;
    localparam logic [2:0] ERR_HEX_UNI   = slu_pkg::ERR_HEX_UNI;
    localparam logic [2:0] ERR_SURROGATE = slu_pkg::ERR_SURROGATE;
    localparam logic [2:0] ERR_TRUNC     = slu_pkg::ERR_TRUNC;
    localparam logic [2:0] ERR_LEAD      = slu_pkg::ERR_LEAD;

    // one result as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } lit_result_t;

    // directed row: typed rows carry a single expected result
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic [1:0] kind;
        logic [2:0] code;
        logic [7:0] data;
    } stim_row_t;

    typedef enum logic [2:0] {
        LIT_BODY,
        LIT_ESC,
        LIT_HEX_ASCII,
        LIT_HEX_UNI,
        LIT_UTF8_CONT
    } lit_mode_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;

    // side info that travels with the current input byte
    logic        in_typed;
    lit_result_t in_typed_res;

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int bytes_sent;
    int results_checked;
    int ends_seen;
    int errors_seen;
    int wide_bytes_seen;
    int mismatch_count;

    // predictor state
    lit_mode_t   lit_mode = LIT_BODY;
    logic [2:0]  digits_left = '0;
    logic [20:0] code_accum = '0;
    logic [1:0]  cont_left = '0;
    lit_result_t step_out [4];
    int          step_cnt;

    lit_result_t awaited_results [$];
    logic [7:0]  token_bytes [$];
    stim_row_t   directed_rows [32];

    string_literal_unescape dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 10);
        return 5'h10;
    endfunction

    task automatic add_result(input logic [7:0] d, input logic [1:0] k, input logic [2:0] c);
        step_out[step_cnt] = '{d, k, c, 1'b0};
        step_cnt++;
    endtask

    task automatic clear_literal();
        lit_mode    = LIT_BODY;
        digits_left = '0;
        code_accum  = '0;
        cont_left   = '0;
    endtask

    task automatic flag_error(input logic [2:0] c);
        clear_literal();
        add_result(8'h00, KIND_ERR, c);
    endtask

    // advance the unescaper by one raw byte; results land in step_out
    task automatic unescape_step(input logic [7:0] b);
        logic [4:0]  h;
        logic [20:0] cp;
        logic        bad;
        begin
            h = hex_nibble(b);
            step_cnt = 0;
            case (lit_mode)
                LIT_ESC:
                begin
                    lit_mode = LIT_BODY;
                    case (b)
                        "'", "\"", "\\": add_result(b, KIND_DATA, ERR_NONE);
                        "0": add_result(8'h00, KIND_DATA, ERR_NONE);
                        "a": add_result(8'h07, KIND_DATA, ERR_NONE);
                        "b": add_result(8'h08, KIND_DATA, ERR_NONE);
                        "f": add_result(8'h0C, KIND_DATA, ERR_NONE);
                        "n": add_result(8'h0A, KIND_DATA, ERR_NONE);
                        "r": add_result(8'h0D, KIND_DATA, ERR_NONE);
                        "t": add_result(8'h09, KIND_DATA, ERR_NONE);
                        "v": add_result(8'h0B, KIND_DATA, ERR_NONE);
                        "x":
                        begin
                            lit_mode    = LIT_HEX_ASCII;
                            digits_left = 3'd2;
                            code_accum  = '0;
                        end
                        "u":
                        begin
                            lit_mode    = LIT_HEX_UNI;
                            digits_left = 3'd6;
                            code_accum  = '0;
                        end
                        default: flag_error(ERR_LITERAL);
                    endcase
                end
                LIT_HEX_ASCII:
                begin
                    if (digits_left >= 3'd2)
                    begin
                        if (b < "0" || b > "7")
                            flag_error(ERR_HEX_ASCII);
                        else
                        begin
                            code_accum  = 21'(h[3:0]);
                            digits_left = 3'd1;
                        end
                    end
                    else if (h[4])
                        flag_error(ERR_HEX_ASCII);
                    else
                    begin
                        cp = code_accum;
                        clear_literal();
                        add_result({cp[3:0], h[3:0]}, KIND_DATA, ERR_NONE);
                    end
                end
                LIT_HEX_UNI:
                begin
                    if (digits_left >= 3'd6)
                        bad = (b != "0" && b != "1");
                    else if (digits_left == 3'd5)
                        bad = h[4] || (code_accum == 21'd1 && h != 5'd0);
                    else
                        bad = h[4];
                    if (bad)
                        flag_error(ERR_HEX_UNI);
                    else
                    begin
                        code_accum  = {code_accum[16:0], h[3:0]};
                        digits_left = digits_left - 3'd1;
                        if (digits_left == 3'd0)
                        begin
                            cp = code_accum;
                            clear_literal();
                            // surrogates first, then the range cap, then UTF-8 bytes
                            if (cp >= 21'hD800 && cp <= 21'hDFFF)
                                flag_error(ERR_SURROGATE);
                            else if (cp > 21'h10FFFF)
                                flag_error(ERR_HEX_UNI);
                            else if (cp <= 21'h7F)
                                add_result(cp[7:0], KIND_DATA, ERR_NONE);
                            else if (cp <= 21'h7FF)
                            begin
                                add_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
                                add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
                            end
                            else if (cp <= 21'hFFFF)
                            begin
                                add_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
                                add_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                                add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
                            end
                            else
                            begin
                                add_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
                                add_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
                                add_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                                add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
                            end
                        end
                    end
                end
                LIT_UTF8_CONT:
                begin
                    if (b[7:6] != 2'b10)
                        flag_error(ERR_TRUNC);
                    else
                    begin
                        add_result(b, KIND_DATA, ERR_NONE);
                        cont_left = cont_left - 2'd1;
                        if (cont_left == 2'd0)
                            lit_mode = LIT_BODY;
                    end
                end
                default:
                begin
                    if (b == "\"")
                    begin
                        clear_literal();
                        add_result(8'h00, KIND_END, ERR_NONE);
                    end
                    else if (!b[7])
                    begin
                        if (b == "\\")
                            lit_mode = LIT_ESC;
                        else if (b == 8'h0A || b == 8'h00)
                            flag_error(ERR_LITERAL);
                        else
                            add_result(b, KIND_DATA, ERR_NONE);
                    end
                    else if (b >= 8'hC0 && b <= 8'hF7)
                    begin
                        cont_left = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
                        lit_mode  = LIT_UTF8_CONT;
                        add_result(b, KIND_DATA, ERR_NONE);
                    end
                    else
                        flag_error(ERR_LEAD);
                end
            endcase
            if (step_cnt > 0)
                step_out[step_cnt - 1].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: input transfers feed the predictor, output transfers are checked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        lit_result_t got;
        lit_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                unescape_step(in_byte);
                if (in_typed)
                    awaited_results.push_back(in_typed_res);
                else
                    for (int i = 0; i < step_cnt; i++)
                        awaited_results.push_back(step_out[i]);
            end
            if (out_valid && out_ready)
            begin
                got = '{out_byte, kind, error_code, last};
                results_checked++;
                if (kind == KIND_END)
                    ends_seen++;
                if (kind == KIND_ERR)
                    errors_seen++;
                if (kind == KIND_DATA && out_byte[7])
                    wide_bytes_seen++;
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result byte=%02h kind=%0d code=%0d last=%0b",
                                 $realtime, got.data, got.kind, got.code, got.last);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind
                        || got.code !== want.code || got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("%0t: mismatch expected byte=%02h kind=%0d code=%0d ",
                                   $realtime, want.data, want.kind, want.code);
                            $display("last=%0b, got byte=%02h kind=%0d code=%0d last=%0b",
                                     want.last, got.data, got.kind, got.code, got.last);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: stall at random per phase
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // one input transfer; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic typed, input lit_result_t tr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        in_typed     <= typed;
        in_typed_res <= tr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // hold the sender until every awaited result has been seen
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0" + n);
        return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
    endfunction

    // backslash-u plus six hex digits of v (top digit is bit 20 only)
    task automatic queue_uni_escape(input logic [20:0] v);
        token_bytes.push_back("\\");
        token_bytes.push_back("u");
        token_bytes.push_back(hex_char({3'b000, v[20]}));
        for (int k = 4; k >= 0; k--)
            token_bytes.push_back(hex_char(4'(v >> (4 * k))));
    endtask

    // one random token: mostly well-formed, some noise and broken sequences
    task automatic send_token();
        logic [7:0]  v;
        logic [20:0] cp;
        int          pick;
        int          n;
        begin
            token_bytes.delete();
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                // plain text
                do
                    v = 8'($urandom_range(127, 1));
                while (v == 8'h0A || v == "\"" || v == "\\");
                token_bytes.push_back(v);
            end
            else if (pick < 42)
            begin
                // simple escapes
                token_bytes.push_back("\\");
                case ($urandom_range(10))
                    0: token_bytes.push_back("'");
                    1: token_bytes.push_back("\"");
                    2: token_bytes.push_back("\\");
                    3: token_bytes.push_back("0");
                    4: token_bytes.push_back("a");
                    5: token_bytes.push_back("b");
                    6: token_bytes.push_back("f");
                    7: token_bytes.push_back("n");
                    8: token_bytes.push_back("r");
                    9: token_bytes.push_back("t");
                    default: token_bytes.push_back("v");
                endcase
            end
            else if (pick < 52)
            begin
                // \x with two good digits
                token_bytes.push_back("\\");
                token_bytes.push_back("x");
                token_bytes.push_back(8'("0" + $urandom_range(7)));
                token_bytes.push_back(hex_char(4'($urandom_range(15))));
            end
            else if (pick < 64)
            begin
                // \u with a legal code point of each encoded length
                case ($urandom_range(3))
                    0: cp = 21'($urandom_range(16'h7F));
                    1: cp = 21'($urandom_range(16'h7FF, 16'h80));
                    2:
                    begin
                        do
                            cp = 21'($urandom_range(16'hFFFF, 16'h800));
                        while (cp >= 21'hD800 && cp <= 21'hDFFF);
                    end
                    default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
                endcase
                queue_uni_escape(cp);
            end
            else if (pick < 76)
            begin
                // well-formed multibyte UTF-8
                n = $urandom_range(3, 1);
                case (n)
                    1: token_bytes.push_back(8'($urandom_range(8'hDF, 8'hC0)));
                    2: token_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
                    default: token_bytes.push_back(8'($urandom_range(8'hF7, 8'hF0)));
                endcase
                for (int k = 0; k < n; k++)
                    token_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            else if (pick < 82)
                token_bytes.push_back("\"");
            else
            begin
                // noise and broken sequences
                case ($urandom_range(5))
                    0: token_bytes.push_back(8'($urandom_range(255)));
                    1:
                    begin
                        token_bytes.push_back("\\");
                        token_bytes.push_back(8'($urandom_range(255)));
                    end
                    2:
                    begin
                        token_bytes.push_back("\\");
                        token_bytes.push_back("x");
                        token_bytes.push_back(8'($urandom_range(255)));
                        token_bytes.push_back(8'($urandom_range(255)));
                    end
                    3:
                    begin
                        queue_uni_escape(21'($urandom_range(32'h1FFFFF)));
                        if ($urandom_range(1))
                            token_bytes[2 + $urandom_range(5)] = 8'($urandom_range(255));
                    end
                    4:
                    begin
                        token_bytes.push_back(8'($urandom_range(8'hF7, 8'hC0)));
                        n = $urandom_range(2);
                        for (int k = 0; k < n; k++)
                            token_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                        do
                            v = 8'($urandom_range(255));
                        while (v[7:6] == 2'b10);
                        token_bytes.push_back(v);
                    end
                    default: queue_uni_escape(21'($urandom_range(16'hDFFF, 16'hD800)));
                endcase
            end
            foreach (token_bytes[k])
                send_byte(token_bytes[k], 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int send_pct [4];
        int recv_pct [4];
        int phase_start;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        in_typed       = 1'b0;
        in_typed_res   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pct = '{0, 57, 0, 23};
        recv_pct = '{0, 0, 57, 23};

        directed_rows = '{
            '{8'h7F, 1'b1, KIND_DATA, ERR_NONE,      8'h7F},
            '{8'h22, 1'b1, KIND_END,  ERR_NONE,      8'h00},
            '{8'h0A, 1'b1, KIND_ERR,  ERR_LITERAL,   8'h00},
            '{8'h00, 1'b1, KIND_ERR,  ERR_LITERAL,   8'h00},
            '{8'hFF, 1'b1, KIND_ERR,  ERR_LEAD,      8'h00},
            '{8'h80, 1'b1, KIND_ERR,  ERR_LEAD,      8'h00},
            // unknown escape letter
            '{"\\",  1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"q",   1'b1, KIND_ERR,  ERR_LITERAL,   8'h00},
            // \x with a first digit above 7
            '{"\\",  1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"x",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"8",   1'b1, KIND_ERR,  ERR_HEX_ASCII, 8'h00},
            // largest code point, four-byte burst
            '{"\\",  1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"u",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"1",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"0",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"F",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"F",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"f",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"f",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            // surrogate code point
            '{"\\",  1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"u",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"0",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"0",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"d",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"8",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"0",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"0",   1'b1, KIND_ERR,  ERR_SURROGATE, 8'h00},
            // quote where a continuation byte belongs
            '{8'hE0, 1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{8'h22, 1'b1, KIND_ERR,  ERR_TRUNC,     8'h00},
            // \u with a first digit above 1
            '{"\\",  1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"u",   1'b0, KIND_DATA, ERR_NONE,      8'h00},
            '{"2",   1'b1, KIND_ERR,  ERR_HEX_UNI,   8'h00}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, no idling
        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].typed,
                      '{directed_rows[i].data, directed_rows[i].kind,
                        directed_rows[i].code, 1'b1});
        drain_results();

        // random token streams under each idle pattern
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < BytesPerPhase)
            begin
                send_token();
                if ($urandom_range(99) < 3)
                    drain_results();
            end
            drain_results();
        end

        repeat (DrainCycles) @(negedge clk);

        $display("Sent %0d input bytes over four idle patterns; checked %0d results",
                 bytes_sent, results_checked);
        $display("including %0d literal ends, %0d errors and %0d non-ASCII data bytes.",
                 ends_seen, errors_seen, wide_bytes_seen);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
